>>> hw/rtl/wsr_pkg.sv
// Shared types and constants for the exact Wilcoxon signed-rank p-value core.
// No dependencies; imported by the core top level.
`timescale 1ns / 1ps

package wsr_pkg;

    // Width of one subset count and of a running sum of counts (up to 2^32).
    localparam int CNT_W = 33;

    // Width of the p-value: unsigned fixed point, 2 integer and 32 fraction bits.
    localparam int P_W = 34;

    // Number of fraction bits in the p-value.
    localparam int FRAC_W = 32;

    typedef logic [CNT_W-1:0] count_t;
    typedef logic [P_W-1:0]   pval_t;

    // Tail mode codes; any other code selects the lower tail.
    localparam logic [1:0] TAIL_TWO   = 2'd0;
    localparam logic [1:0] TAIL_UPPER = 2'd1;

endpackage

>>> hw/rtl/wilcoxon_signed_rank_exact_pvalue_core.sv
// Exact Wilcoxon signed-rank p-value core. Depends on wsr_pkg and wsr_ram.
// Steps: with r = min(query sum, TABLE_DEPTH-1), clear table entries 0..r, then run
// one update pass for each l = 1..min(n, r), then a prefix-sum scan over entries 0..r,
// with setup and pass control around them. One item at a time; all steps share the single
// adder and the count table port. A finished result waits in the output register while
// the next item is taken in.
// Reset (rst_n low, asynchronous) returns the sequencer to idle and drops any held result;
// the table is not cleared.
`timescale 1ns / 1ps

module wilcoxon_signed_rank_exact_pvalue_core
    import wsr_pkg::*;
#(
    parameter int MAX_N       = 32,
    parameter int TABLE_DEPTH = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic [5:0]  set_size,
    input  logic [9:0]  rank_sum,
    input  logic [1:0]  tail_mode,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [33:0] p_value
);

    localparam int         AW       = $clog2(TABLE_DEPTH);
    localparam logic [9:0] LAST_IDX = 10'(TABLE_DEPTH - 1);
    localparam logic [5:0] MAX_N_V  = 6'(MAX_N);

    // Sequencer states.
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SETUP = 4'd1;
    localparam logic [3:0] S_CLR   = 4'd2;
    localparam logic [3:0] S_PASS  = 4'd3;
    localparam logic [3:0] S_DP    = 4'd4;
    localparam logic [3:0] S_SUM   = 4'd5;
    localparam logic [3:0] S_DRAIN = 4'd6;
    localparam logic [3:0] S_FIN   = 4'd7;

    logic [3:0]    state_reg, state_next;
    logic [5:0]    n_reg, n_next;
    logic [9:0]    x_reg, x_next;
    logic [1:0]    mode_reg, mode_next;
    logic [AW-1:0] xr_reg, xr_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [5:0]    l_reg, l_next;
    count_t        acc_reg, acc_next;
    logic          cmp_reg, cmp_next;
    logic          dbl_reg, dbl_next;
    logic          rd_vld_reg, rd_vld_next;
    logic          rd_dp_reg, rd_dp_next;
    logic [AW-1:0] wr_addr_reg, wr_addr_next;
    pval_t         p_reg, p_next;
    logic          out_valid_reg, out_valid_next;

    // Table port signals.
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    count_t        ram_wdata;
    logic [AW-1:0] ram_raddr0;
    logic [AW-1:0] ram_raddr1;
    count_t        ram_rdata0;
    count_t        ram_rdata1;

    // Setup terms derived from the captured item.
    logic [10:0]   prod;
    logic [9:0]    top_sum;
    logic [9:0]    half_sum;
    logic          use_upper;
    logic          one_case;
    logic [9:0]    query;
    logic [9:0]    query_lim;
    count_t        full;

    // Shared adder and final scaling.
    count_t        add_a;
    count_t        add_sum;
    count_t        fin_val;
    logic [5:0]    shamt;

    wsr_ram #(
        .WIDTH (CNT_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk    (clk),
        .we     (ram_we),
        .waddr  (ram_waddr),
        .wdata  (ram_wdata),
        .raddr0 (ram_raddr0),
        .rdata0 (ram_rdata0),
        .raddr1 (ram_raddr1),
        .rdata1 (ram_rdata1)
    );

    // Top sum n(n+1)/2, midpoint n(n+1)/4 and the sum that is to be looked up.
    assign prod      = 11'(n_reg) * (11'(n_reg) + 11'd1);
    assign top_sum   = prod[10:1];
    assign half_sum  = {1'b0, prod[10:2]};
    assign use_upper = (mode_reg == TAIL_UPPER)
                       || ((mode_reg == TAIL_TWO) && (x_reg > half_sum));
    assign one_case  = (mode_reg == TAIL_UPPER) && (x_reg == 10'd0);
    assign query     = use_upper ? (x_reg - 10'd1) : x_reg;
    assign query_lim = (query > LAST_IDX) ? LAST_IDX : query;
    assign full      = count_t'(1) << n_reg;

    // The one adder: table update during passes, running sum during the prefix scan.
    assign add_a   = rd_dp_reg ? ram_rdata1 : acc_reg;
    assign add_sum = add_a + ram_rdata0;

    // Final scaling of the count to 32 fraction bits, doubled for two-sided.
    assign fin_val = cmp_reg ? (full - acc_reg) : acc_reg;
    assign shamt   = 6'd32 - n_reg + {5'd0, dbl_reg};

    // Read addresses follow the index; the second port reads the entry l below.
    assign ram_raddr0 = idx_reg;
    assign ram_raddr1 = idx_reg - AW'(l_reg);

    // Write port: clearing writes, else the pipelined table update.
    always_comb
    begin
        if (state_reg == S_CLR)
        begin
            ram_we    = 1'b1;
            ram_waddr = idx_reg;
            ram_wdata = (idx_reg == '0) ? count_t'(1) : '0;
        end
        else
        begin
            ram_we    = rd_vld_reg && rd_dp_reg;
            ram_waddr = wr_addr_reg;
            ram_wdata = add_sum;
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        x_next         = x_reg;
        mode_next      = mode_reg;
        xr_next        = xr_reg;
        idx_next       = idx_reg;
        l_next         = l_reg;
        acc_next       = acc_reg;
        cmp_next       = cmp_reg;
        dbl_next       = dbl_reg;
        rd_vld_next    = 1'b0;
        rd_dp_next     = rd_dp_reg;
        wr_addr_next   = wr_addr_reg;
        p_next         = p_reg;
        out_valid_next = out_valid_reg;

        // Prefix-scan data returns in the cycle after its read.
        if (rd_vld_reg && !rd_dp_reg)
        begin
            acc_next = add_sum;
        end

        // The held result leaves when the receiver takes it.
        if (out_valid_reg && result_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    n_next     = (set_size > MAX_N_V) ? MAX_N_V : set_size;
                    x_next     = rank_sum;
                    mode_next  = tail_mode;
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                cmp_next = use_upper;
                dbl_next = (mode_reg == TAIL_TWO);
                xr_next  = AW'(query_lim);
                idx_next = '0;
                if (one_case)
                begin
                    // Upper tail at zero is certain: 2^n scaled by 2^(32-n) gives 1.0.
                    acc_next   = full;
                    cmp_next   = 1'b0;
                    state_next = S_FIN;
                end
                else if (query >= top_sum)
                begin
                    // Every subset lies at or below the query.
                    acc_next   = full;
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_CLR;
                end
            end
            S_CLR:
            begin
                if (idx_reg == xr_reg)
                begin
                    l_next     = 6'd1;
                    state_next = S_PASS;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            S_PASS:
            begin
                // This cycle also lets the last write of the previous pass land.
                if ((10'(l_reg) > 10'(xr_reg)) || (l_reg > n_reg))
                begin
                    idx_next   = '0;
                    acc_next   = '0;
                    state_next = S_SUM;
                end
                else
                begin
                    idx_next   = xr_reg;
                    state_next = S_DP;
                end
            end
            S_DP:
            begin
                rd_vld_next  = 1'b1;
                rd_dp_next   = 1'b1;
                wr_addr_next = idx_reg;
                if (idx_reg == AW'(l_reg))
                begin
                    l_next     = l_reg + 6'd1;
                    state_next = S_PASS;
                end
                else
                begin
                    idx_next = idx_reg - AW'(1);
                end
            end
            S_SUM:
            begin
                rd_vld_next = 1'b1;
                rd_dp_next  = 1'b0;
                if (idx_reg == xr_reg)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            S_DRAIN:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                // Load the output register once the previous result has gone.
                if (!out_valid_reg || result_ready)
                begin
                    p_next         = pval_t'(fin_val) << shamt;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_vld_reg    <= rd_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        x_reg       <= x_next;
        mode_reg    <= mode_next;
        xr_reg      <= xr_next;
        idx_reg     <= idx_next;
        l_reg       <= l_next;
        acc_reg     <= acc_next;
        cmp_reg     <= cmp_next;
        dbl_reg     <= dbl_next;
        rd_dp_reg   <= rd_dp_next;
        wr_addr_reg <= wr_addr_next;
        p_reg       <= p_next;
    end

    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = out_valid_reg;
    assign p_value      = p_reg;

    // A waiting result stays valid and unchanged until it is taken.
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=> (result_valid && $stable(p_value)))
        else $error("waiting result dropped or changed");

    // A table update never writes the entry being read in the same cycle.
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DP && rd_vld_reg && rd_dp_reg) |-> (wr_addr_reg != idx_reg))
        else $error("table update collides with a read");

    // The cumulative count never exceeds the number of subsets.
    a_cdf_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) |-> (acc_reg <= full))
        else $error("cumulative count above 2^n");

    // A result is posted in the cycle after the final scaling finds the output free.
    a_fin_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && (!result_valid || result_ready))
        |=> (result_valid && state_reg == S_IDLE))
        else $error("result not posted after scaling");

endmodule

>>> hw/rtl/wsr_ram.sv
// Generic RAM with one write port and two registered read ports.
// No dependencies; used by the core for the subset count table.
`timescale 1ns / 1ps

module wsr_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr0,
    output logic [WIDTH-1:0]         rdata0,
    input  logic [$clog2(DEPTH)-1:0] raddr1,
    output logic [WIDTH-1:0]         rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write and two registered reads per cycle.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule

>>> sim/tb.sv
// Self-checking testbench for the exact Wilcoxon signed-rank p-value core.
// Depends on wsr_pkg and the core RTL; a scoreboard class predicts each p-value.
`timescale 1ns / 1ps

module tb;
    import wsr_pkg::*;

    // Tail codes the package does not name.
    localparam logic [1:0] TAIL_LOWER = 2'd2;
    localparam logic [1:0] TAIL_SPARE = 2'd3;

    // Cycles with no transfer on either side before the run is abandoned.
    localparam int WATCHDOG_LIMIT = 150000;
    localparam int DRAIN_CYCLES   = 64;
    localparam int RANDOM_ITEMS   = 80;

    // Keeps the predicted p-values in order and checks results against them.
    class pvalue_scoreboard;
        localparam int SIZE_CAP    = 32;
        localparam int TABLE_DEPTH = 1024;

        typedef struct {
            logic [5:0] n;
            logic [9:0] x;
            logic [1:0] mode;
            pval_t      p;
        } pending_t;

        pending_t pending_p[$];
        int       mismatches;

        function new();
            mismatches = 0;
        endfunction

        // Number of subsets of {1..n} whose sum is at most x, held to 33 bits.
        function longint unsigned subsets_at_most(int n, int x);
            longint unsigned ways[0:TABLE_DEPTH-1];
            longint unsigned mask33;
            int top;
            int lim;
            int xs;
            mask33 = (64'd1 << 33) - 64'd1;
            top = n * (n + 1) / 2;
            if (x >= top)
                return 64'd1 << n;
            lim = (top > TABLE_DEPTH - 1) ? TABLE_DEPTH - 1 : top;
            for (int s = 0; s <= lim; s++)
                ways[s] = 64'd0;
            ways[0] = 64'd1;
            // Subset-sum counts, adding one element at a time.
            for (int l = 1; l <= n; l++)
                for (int s = lim; s >= l; s--)
                    ways[s] = (ways[s] + ways[s - l]) & mask33;
            // Running sum turns counts per sum into counts up to each sum.
            for (int s = 1; s <= lim; s++)
                ways[s] = (ways[s] + ways[s - 1]) & mask33;
            xs = (x > lim) ? lim : x;
            return ways[xs];
        endfunction

        function pval_t p_value_of(logic [5:0] n_in, logic [9:0] x_in, logic [1:0] mode);
            int n;
            int x;
            int sh;
            longint unsigned full;
            longint unsigned p;
            n = (n_in > SIZE_CAP) ? SIZE_CAP : int'(n_in);
            x = int'(x_in);
            full = 64'd1 << n;
            sh = 32 - n;
            case (mode)
                TAIL_TWO:
                begin
                    // Double the smaller tail; no clamp, so 2.0 is reachable.
                    if (x > n * (n + 1) / 4)
                        p = ((full - subsets_at_most(n, x - 1)) << sh) << 1;
                    else
                        p = (subsets_at_most(n, x) << sh) << 1;
                end
                TAIL_UPPER:
                begin
                    if (x == 0)
                        p = 64'd1 << 32;
                    else
                        p = (full - subsets_at_most(n, x - 1)) << sh;
                end
                default:
                begin
                    p = subsets_at_most(n, x) << sh;
                end
            endcase
            return p[P_W-1:0];
        endfunction

        function void note_item(logic [5:0] n, logic [9:0] x, logic [1:0] mode);
            pending_t e;
            e.n = n;
            e.x = x;
            e.mode = mode;
            e.p = p_value_of(n, x, mode);
            pending_p.push_back(e);
        endfunction

        task report_mismatch(string what);
            $display("%0t ns: mismatch: %s", $realtime, what);
            mismatches++;
        endtask

        task check_result(pval_t got);
            pending_t e;
            if (pending_p.size() == 0)
            begin
                report_mismatch($sformatf("result p_value=%h with nothing pending", got));
            end
            else
            begin
                e = pending_p.pop_front();
                if (got !== e.p)
                    report_mismatch($sformatf("n=%0d x=%0d mode=%0d p_value=%h, want %h",
                                              e.n, e.x, e.mode, got, e.p));
            end
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_ready;
    logic [5:0]  set_size = '0;
    logic [9:0]  rank_sum = '0;
    logic [1:0]  tail_mode = '0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    logic [33:0] p_value;

    pvalue_scoreboard sb = new();

    int          burst_left = 0;
    int          rx_stall = 0;
    logic [31:0] rx_cycle = '0;
    int          idle_cycles = 0;

    wilcoxon_signed_rank_exact_pvalue_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .set_size     (set_size),
        .rank_sum     (rank_sum),
        .tail_mode    (tail_mode),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .p_value      (p_value)
    );

    // 2 ns clock.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Watch both channels; results are checked before a same-edge item is noted.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            sb.check_result(p_value);
        if (rst_n && item_valid && item_ready)
            sb.note_item(set_size, rank_sum, tail_mode);
    end

    // Receiver: calm stretches with ready held high, busy stretches with random
    // ready and an occasional long stall.
    always @(posedge clk)
    begin
        rx_cycle <= rx_cycle + 1;
        if (rx_stall > 0)
        begin
            result_ready <= 1'b0;
            rx_stall <= rx_stall - 1;
        end
        else if (rx_cycle[13])
        begin
            result_ready <= 1'b1;
        end
        else
        begin
            result_ready <= 1'($urandom_range(0, 1));
            if ($urandom_range(0, 63) == 0)
                rx_stall <= $urandom_range(10, 80);
        end
    end

    // Give up when no transfer happens for too long.
    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Present one item and hold it until its transfer; bursts are mostly separated by gaps.
    task send_item(input int n, input int x, input logic [1:0] mode);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 8);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        item_valid <= 1'b1;
        set_size <= 6'(n);
        rank_sum <= 10'(x);
        tail_mode <= mode;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
    endtask

    // Extremes of every field, each tail, the midpoint split of the two-sided
    // test, statistics past the top sum, an empty set and oversized sets.
    task run_directed();
        send_item(0, 0, TAIL_TWO);
        send_item(0, 0, TAIL_UPPER);
        send_item(0, 3, TAIL_TWO);
        send_item(1, 0, TAIL_TWO);
        send_item(1, 1, TAIL_UPPER);
        send_item(1, 1, TAIL_LOWER);
        send_item(5, 7, TAIL_TWO);
        send_item(5, 8, TAIL_TWO);
        send_item(5, 0, TAIL_UPPER);
        send_item(5, 15, TAIL_LOWER);
        send_item(5, 14, TAIL_UPPER);
        send_item(5, 16, TAIL_SPARE);
        send_item(12, 39, TAIL_TWO);
        send_item(32, 0, TAIL_TWO);
        send_item(32, 264, TAIL_TWO);
        send_item(32, 265, TAIL_TWO);
        send_item(32, 1, TAIL_UPPER);
        send_item(32, 528, TAIL_LOWER);
        send_item(32, 1023, TAIL_UPPER);
        send_item(63, 527, TAIL_SPARE);
        send_item(63, 1023, TAIL_TWO);
        send_item(20, 1023, TAIL_LOWER);
    endtask

    // Mostly small sets, since the core's time grows roughly with n times the sum.
    task run_random(input int count);
        int pick;
        int n;
        int n_eff;
        int top;
        int x;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 8)
                n = $urandom_range(0, 12);
            else if (pick == 8)
                n = $urandom_range(13, 31);
            else
                n = $urandom_range(32, 63);
            n_eff = (n > 32) ? 32 : n;
            top = n_eff * (n_eff + 1) / 2;
            if ($urandom_range(0, 9) < 7)
                x = $urandom_range(0, (top + 1 > 1023) ? 1023 : top + 1);
            else
                x = $urandom_range(0, 1023);
            send_item(n, x, 2'($urandom_range(0, 3)));
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random(RANDOM_ITEMS);
        item_valid <= 1'b0;
        while (sb.pending_p.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
